// ===== rtl/sbbf_pkg.sv =====
// Shared types, constants and a helper function of the split-block Bloom filter.
package sbbf_pkg;

	localparam int WORDS       = 8;
	localparam int WORD_W      = 32;
	localparam int BLOCK_W     = WORDS * WORD_W;
	localparam int SEL_W       = 5;
	localparam int BIT_SHIFT   = 27;
	localparam int HALF_W      = 32;
	localparam int HASH_W      = 64;
	localparam int NUM_BLOCKS_W = 11;

	localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RST = 11'd1024;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [WORD_W-1:0] SALT [WORDS] = '{
		32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
		32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
	};

	typedef logic [SEL_W-1:0] sel_t;
	typedef sel_t [WORDS-1:0] sel_vec_t;

	// Request as it leaves the index stage.
	typedef struct packed {
		logic     valid;
		logic     opcode;
		sel_vec_t sel;
	} req_t;

	// One set bit in each 32-bit word of the block.
	function automatic logic [BLOCK_W-1:0] bit_mask(input sel_vec_t sel);
		logic [BLOCK_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORDS; i++) begin
			m[i*WORD_W +: WORD_W] = WORD_W'(1) << sel[i];
		end
		return m;
	endfunction

endpackage

// ===== rtl/sbbf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sbbf_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/sbbf_index.sv =====
// Index stage: block select from the upper hash half and bit selects from the salts.
module sbbf_index #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  accept,
	input  logic                                  opcode,
	input  logic [sbbf_pkg::HASH_W-1:0]           hash,
	input  logic [sbbf_pkg::NUM_BLOCKS_W-1:0]     num_blocks,
	output sbbf_pkg::req_t                        req_s1,
	output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] block_s1
);

	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PW = sbbf_pkg::HALF_W + sbbf_pkg::NUM_BLOCKS_W;

	logic [sbbf_pkg::NUM_BLOCKS_W-1:0] eff;
	logic [PW-1:0]                     prod;
	logic [sbbf_pkg::NUM_BLOCKS_W-1:0] blk_full;
	logic [BW-1:0]                     blk;
	sbbf_pkg::sel_vec_t                sel;

	always_comb begin
		if (32'(num_blocks) > MAX_BLOCKS) begin
			eff = sbbf_pkg::NUM_BLOCKS_W'(MAX_BLOCKS);
		end else begin
			eff = num_blocks;
		end
		prod     = PW'(hash[sbbf_pkg::HASH_W-1:sbbf_pkg::HALF_W]) * PW'(eff);
		blk_full = prod[PW-1:sbbf_pkg::HALF_W];
		if (32'(blk_full) >= MAX_BLOCKS) begin
			blk = BW'(MAX_BLOCKS - 1);
		end else begin
			blk = BW'(blk_full);
		end
	end

	// Low 32 bits of key times salt; the top five bits pick the bit in each word.
	always_comb begin
		logic [sbbf_pkg::WORD_W-1:0] p;
		for (int i = 0; i < sbbf_pkg::WORDS; i++) begin
			p      = hash[sbbf_pkg::HALF_W-1:0] * sbbf_pkg::SALT[i];
			sel[i] = p[sbbf_pkg::WORD_W-1:sbbf_pkg::BIT_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (en) begin
			req_s1.valid  <= accept;
			req_s1.opcode <= opcode;
			req_s1.sel    <= sel;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			block_s1 <= blk;
		end
	end

endmodule

// ===== rtl/split_block_bloom_filter.sv =====
// Split-block Bloom filter: 256-bit blocks kept in one RAM, updated by read-modify-write.
// A check request passes the index register, the lookup stage and the result register.
// Throughput: one request per cycle; a stalled result halts the pipeline once the next check
// reaches the lookup stage. A write to the block read in the same cycle is forwarded.
// Reset clears the filter with a pass over all MAX_BLOCKS blocks, one block per cycle,
// during which cmd_stall is high; num_blocks resets to 1024.
module split_block_bloom_filter #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sbbf_pkg::NUM_BLOCKS_W-1:0] cfg_wr_data,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic                              opcode,
	input  logic [sbbf_pkg::HASH_W-1:0]       hash,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              present
);

	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	logic [sbbf_pkg::NUM_BLOCKS_W-1:0] num_blocks_q;
	logic                              clearing_q;
	logic [BW-1:0]                     clr_q;

	sbbf_pkg::req_t                    req_s1;
	logic [BW-1:0]                     block_s1;

	logic                              valid_s2;
	logic                              op_s2;
	logic [sbbf_pkg::BLOCK_W-1:0]      mask_s2;
	logic [BW-1:0]                     block_s2;

	logic                              fwd_valid_q;
	logic [BW-1:0]                     fwd_addr_q;
	logic [sbbf_pkg::BLOCK_W-1:0]      fwd_data_q;

	logic                              res_valid_q;
	logic                              present_q;

	logic                              adv;
	logic                              accept;
	logic                              ins_we;
	logic [sbbf_pkg::BLOCK_W-1:0]      rdata;
	logic [sbbf_pkg::BLOCK_W-1:0]      cur;
	logic [sbbf_pkg::BLOCK_W-1:0]      upd;
	logic                              hit;
	logic                              ram_we;
	logic [BW-1:0]                     ram_waddr;
	logic [sbbf_pkg::BLOCK_W-1:0]      ram_wdata;

	// The pipeline only halts when a check result cannot leave.
	assign adv = !(valid_s2 && (op_s2 == sbbf_pkg::OP_CHECK) && res_valid_q && res_stall);
	assign cmd_stall = clearing_q || !adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= sbbf_pkg::NUM_BLOCKS_RST;
		end else if (cfg_wr_en) begin
			num_blocks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + BW'(1);
			if (clr_q == BW'(MAX_BLOCKS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	sbbf_index #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.accept    (accept),
		.opcode    (opcode),
		.hash      (hash),
		.num_blocks(num_blocks_q),
		.req_s1    (req_s1),
		.block_s1  (block_s1)
	);

	// The RAM returns old data when read and written at once, so the last
	// write is held in the forwarding registers and replaces the read data on an address match.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == block_s2)) begin
			cur = fwd_data_q;
		end else begin
			cur = rdata;
		end
		upd    = cur | mask_s2;
		hit    = ((cur & mask_s2) == mask_s2);
		ins_we = adv && valid_s2 && (op_s2 == sbbf_pkg::OP_INSERT);
	end

	assign ram_we    = clearing_q || ins_we;
	assign ram_waddr = clearing_q ? clr_q : block_s2;
	assign ram_wdata = clearing_q ? '0 : upd;

	sbbf_ram #(
		.WIDTH(sbbf_pkg::BLOCK_W),
		.DEPTH(MAX_BLOCKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv && req_s1.valid),
		.raddr(block_s1),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= req_s1.valid;
			fwd_valid_q <= ins_we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2      <= req_s1.opcode;
			mask_s2    <= sbbf_pkg::bit_mask(req_s1.sel);
			block_s2   <= block_s1;
			fwd_addr_q <= block_s2;
			fwd_data_q <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && valid_s2 && (op_s2 == sbbf_pkg::OP_CHECK)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && (op_s2 == sbbf_pkg::OP_CHECK)) begin
			present_q <= hit;
		end
	end

	assign res_valid = res_valid_q;
	assign present   = present_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the split-block Bloom filter.
`timescale 1ns / 1ps

module testbench;

	localparam int FILTER_BLOCKS  = 1024;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 75;

	// Mirror of the filter store that predicts the present flag of each check.
	class bloom_scoreboard;
		bit [sbbf_pkg::WORD_W-1:0]       filter_bits [FILTER_BLOCKS*sbbf_pkg::WORDS];
		bit [sbbf_pkg::NUM_BLOCKS_W-1:0] block_count;
		bit                              want_present [$];
		bit [sbbf_pkg::WORD_W-1:0]       salt [sbbf_pkg::WORDS];
		int                              error_count;

		function new();
			salt = '{32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
				32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31};
			block_count = sbbf_pkg::NUM_BLOCKS_RST;
			error_count = 0;
		endfunction

		function void set_blocks(input bit [sbbf_pkg::NUM_BLOCKS_W-1:0] n);
			block_count = n;
		endfunction

		function void note_request(input logic op, input logic [sbbf_pkg::HASH_W-1:0] h);
			bit [63:0] used;
			bit [63:0] prod;
			bit [31:0] row;
			bit [31:0] lane_prod;
			bit [31:0] mask;
			bit        hit;
			// Counts above the store size saturate; a count of zero always picks block 0.
			used = (block_count > FILTER_BLOCKS) ? 64'(FILTER_BLOCKS) : 64'(block_count);
			prod = {32'd0, h[63:32]} * used;
			row = prod[63:32];
			if (row >= FILTER_BLOCKS)
				row = FILTER_BLOCKS - 1;
			hit = 1'b1;
			for (int i = 0; i < sbbf_pkg::WORDS; i++) begin
				lane_prod = h[31:0] * salt[i];
				mask = 32'd1 << lane_prod[31:27];
				if (op == sbbf_pkg::OP_INSERT)
					filter_bits[row*sbbf_pkg::WORDS + i] |= mask;
				else if ((filter_bits[row*sbbf_pkg::WORDS + i] & mask) == 0)
					hit = 1'b0;
			end
			if (op == sbbf_pkg::OP_CHECK)
				want_present.push_back(hit);
		endfunction

		function void check_result(input logic p);
			bit exp_present;
			if (want_present.size() == 0) begin
				$error("present: expected no result, actual %0b", p);
				error_count++;
			end else begin
				exp_present = want_present.pop_front();
				if (p !== exp_present) begin
					$error("present: expected %0b, actual %0b", exp_present, p);
					error_count++;
				end
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [sbbf_pkg::NUM_BLOCKS_W-1:0] cfg_wr_data = '0;
	logic                              cmd_valid = 1'b0;
	logic                              cmd_stall;
	logic                              opcode = sbbf_pkg::OP_CHECK;
	logic [sbbf_pkg::HASH_W-1:0]       hash = '0;
	logic                              res_valid;
	logic                              res_stall = 1'b0;
	logic                              present;

	bloom_scoreboard             sb;
	logic [sbbf_pkg::HASH_W-1:0] known_hashes [$];
	int                          idle_cycles = 0;

	split_block_bloom_filter #(
		.MAX_BLOCKS(FILTER_BLOCKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.hash(hash),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.present(present)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			sb.note_request(opcode, hash);
		if (arst_n && res_valid && !res_stall)
			sb.check_result(present);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side back-pressure: mostly short stalls, some long ones, and clear stretches.
	initial begin
		int run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			res_stall <= 1'b0;
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
			res_stall <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
			repeat (run) @(posedge clk);
		end
	end

	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [sbbf_pkg::HASH_W-1:0] random_hash();
		logic [sbbf_pkg::HASH_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v[63:32] = '1;
			1: v[63:32] = '0;
			default: ;
		endcase
		return v;
	endfunction

	// Holds the request until the block takes it; the payload stays put while stalled.
	task automatic send_request(input logic op, input logic [sbbf_pkg::HASH_W-1:0] h,
			input int gap);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		hash <= h;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// Drains outstanding checks, leaves room for any insert still in flight, then writes the new block count.
	task automatic drain_and_configure(input logic [sbbf_pkg::NUM_BLOCKS_W-1:0] n);
		cmd_valid <= 1'b0;
		while (sb.want_present.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		sb.set_blocks(n);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int count);
		logic                        op;
		logic [sbbf_pkg::HASH_W-1:0] h;
		bit                          burst;
		int                          r;
		burst = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 15 == 0)
				burst = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 35 || known_hashes.size() == 0) begin
				op = sbbf_pkg::OP_INSERT;
				h = random_hash();
				known_hashes.push_back(h);
				if (known_hashes.size() > 96)
					void'(known_hashes.pop_front());
			end else if (r < 65) begin
				op = sbbf_pkg::OP_CHECK;
				h = known_hashes[$urandom_range(0, known_hashes.size() - 1)];
			end else if (r < 80) begin
				// A near miss: one bit away from a hash that is in the filter.
				op = sbbf_pkg::OP_CHECK;
				h = known_hashes[$urandom_range(0, known_hashes.size() - 1)];
				h[$urandom_range(0, sbbf_pkg::HASH_W - 1)] ^= 1'b1;
			end else begin
				op = sbbf_pkg::OP_CHECK;
				h = random_hash();
			end
			send_request(op, h, pick_gap(burst));
		end
	endtask

	initial begin
		logic [sbbf_pkg::NUM_BLOCKS_W-1:0] phase_blocks [6];
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The clear pass after reset holds cmd_stall high.
		while (cmd_stall) @(posedge clk);

		// Directed requests at the reset block count, back to back but for the last two, which follow gaps.
		send_request(sbbf_pkg::OP_CHECK, 64'h0000_0000_0000_0000, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'h0000_0000_0000_0000, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h0000_0000_0000_0000, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'hFFFF_FFFF_0000_0000, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h0000_0000_FFFF_FFFF, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'hFFFF_FFFF_0000_0000, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'h0000_0001_8000_0001, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'h0000_0001_8000_0001, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h0000_0001_8000_0001, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h0000_0001_8000_0000, 0);
		send_request(sbbf_pkg::OP_INSERT, 64'h8000_0000_5555_5555, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h8000_0000_5555_5555, 0);
		send_request(sbbf_pkg::OP_CHECK, 64'h7FFF_FFFF_AAAA_AAAA, 2);
		send_request(sbbf_pkg::OP_CHECK, 64'h8000_0000_5555_5555, 5);

		phase_blocks = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd3, 11'd0};
		phase_blocks[5] = sbbf_pkg::NUM_BLOCKS_W'($urandom_range(4, 1023));
		foreach (phase_blocks[p]) begin
			drain_and_configure(phase_blocks[p]);
			run_random(PHASE_ITEMS);
		end

		cmd_valid <= 1'b0;
		while (sb.want_present.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sbbf_pkg.sv
rtl/sbbf_ram.sv
rtl/sbbf_index.sv
rtl/split_block_bloom_filter.sv
bench/testbench.sv
